// ----- rtl/core/tce_pkg.sv -----
package tce_pkg;

  // tab stops every TAB_STOP_CELLS glyph cells
  localparam int TAB_STOP_CELLS = 8;

  localparam int CUR_W     = 11;
  localparam int DIV_CNT_W = $clog2(CUR_W);
  // width of the tab period in pixels; the pre-saturation column is one bit wider
  localparam int TAB_P_W   = 7 + $clog2(TAB_STOP_CELLS + 1);
  localparam int XW_W      = ((TAB_P_W > CUR_W) ? TAB_P_W : CUR_W) + 1;
  localparam int CMP_W     = (TAB_P_W > CUR_W + 1) ? TAB_P_W : CUR_W + 1;

  localparam int APB_ADDR_W = 5;
  localparam int APB_DATA_W = 32;

  localparam logic [CUR_W-1:0] MAX11 = '1;

  localparam logic [23:0] DEF_FG = 24'hd8d8d8;
  localparam logic [23:0] DEF_BG = 24'h000000;

  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_BS    = 8'h08;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_ESC   = 8'h1A;
  localparam logic [7:0] CH_COMMA = 8'h2C;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_SEMI  = 8'h3B;
  localparam logic [7:0] CH_UP_B  = 8'h42;
  localparam logic [7:0] CH_UP_F  = 8'h46;
  localparam logic [7:0] CH_UP_R  = 8'h52;
  localparam logic [7:0] CH_LO_B  = 8'h62;
  localparam logic [7:0] CH_LO_F  = 8'h66;
  localparam logic [7:0] CH_LO_R  = 8'h72;

  typedef enum logic [1:0] {
    CMD_NONE   = 2'd0,
    CMD_GLYPH  = 2'd1,
    CMD_FILL   = 2'd2,
    CMD_SCROLL = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    SEL_NONE   = 2'd0,
    SEL_PRIM   = 2'd1,
    SEL_SCROLL = 2'd2
  } emit_sel_e;

  // effective configuration, zero cell sizes already forced to one
  typedef struct packed {
    logic [6:0]  cw;
    logic [6:0]  chh;
    logic [6:0]  lh;
    logic [11:0] sw;
    logic [11:0] th;   // text area height, at least one
  } cfg_t;

  typedef struct packed {
    cmd_e             cmd;
    logic [CUR_W-1:0] xs;
    logic [CUR_W-1:0] ys;
    logic [CUR_W-1:0] xe;
    logic [CUR_W-1:0] ye;
    logic [7:0]       glyph;
    logic [23:0]      fg;
    logic [23:0]      bg;
    logic [CUR_W-1:0] cur_x;
    logic [CUR_W-1:0] cur_y;
    logic [31:0]      count;
    logic             last;
  } res_t;

  typedef struct packed {
    logic      accept;
    logic      decode;
    logic      div_step;
    logic      tab_fix;
    logic      line;
    logic      scroll;
    logic      emit;
    emit_sel_e sel;
    logic      last;
  } ctrl_cmd_t;

  typedef struct packed {
    logic is_put;
    logic is_tab;
    logic div_done;
    logic has_prim;
    logic has_scroll;
    logic out_free;
  } ctrl_sts_t;

  function automatic logic [CUR_W-1:0] sat11(input logic [11:0] v);
    return v[11] ? MAX11 : v[CUR_W-1:0];
  endfunction

endpackage

// ----- rtl/core/tce_cfg.sv -----
module tce_cfg import tce_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready,
  output cfg_t                  cfg_o
);

  localparam logic [2:0] REG_CHAR_W   = 3'd0;
  localparam logic [2:0] REG_CHAR_H   = 3'd1;
  localparam logic [2:0] REG_LINE_H   = 3'd2;
  localparam logic [2:0] REG_SCREEN_W = 3'd3;
  localparam logic [2:0] REG_SCREEN_H = 3'd4;
  localparam logic [2:0] REG_RSV_TOP  = 3'd5;

  logic [6:0]  cw_q, chh_q, lh_q;
  logic [11:0] sw_q, sh_q;
  logic [7:0]  rt_q;
  logic [11:0] th_q, th_d;
  logic        wr_en;
  logic [2:0]  idx;

  assign pready = 1'b1;
  assign idx    = paddr[4:2];
  assign wr_en  = psel & penable & pwrite & pready;

  // text height follows the screen registers in the next cycle
  assign th_d = (sh_q > {4'd0, rt_q}) ? sh_q - {4'd0, rt_q} : 12'd1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cw_q  <= 7'd8;
      chh_q <= 7'd16;
      lh_q  <= 7'd16;
      sw_q  <= 12'd1024;
      sh_q  <= 12'd768;
      rt_q  <= 8'd0;
      th_q  <= 12'd768;
    end else begin
      th_q <= th_d;
      if (wr_en) begin
        case (idx)
          REG_CHAR_W:   cw_q  <= pwdata[6:0];
          REG_CHAR_H:   chh_q <= pwdata[6:0];
          REG_LINE_H:   lh_q  <= pwdata[6:0];
          REG_SCREEN_W: sw_q  <= pwdata[11:0];
          REG_SCREEN_H: sh_q  <= pwdata[11:0];
          REG_RSV_TOP:  rt_q  <= pwdata[7:0];
          default: ;
        endcase
      end
    end
  end

  always_comb begin
    case (idx)
      REG_CHAR_W:   prdata = {25'd0, cw_q};
      REG_CHAR_H:   prdata = {25'd0, chh_q};
      REG_LINE_H:   prdata = {25'd0, lh_q};
      REG_SCREEN_W: prdata = {20'd0, sw_q};
      REG_SCREEN_H: prdata = {20'd0, sh_q};
      REG_RSV_TOP:  prdata = {24'd0, rt_q};
      default:      prdata = '0;
    endcase
  end

  assign cfg_o.cw  = (cw_q == 7'd0) ? 7'd1 : cw_q;
  assign cfg_o.chh = (chh_q == 7'd0) ? 7'd1 : chh_q;
  assign cfg_o.lh  = (lh_q == 7'd0) ? 7'd1 : lh_q;
  assign cfg_o.sw  = sw_q;
  assign cfg_o.th  = th_q;

endmodule

// ----- rtl/core/tce_ctrl.sv -----
module tce_ctrl import tce_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  ctrl_sts_t sts_i,
  output ctrl_cmd_t ctl_o
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_DECODE,
    S_DIV,
    S_TAB,
    S_LINE,
    S_SCROLL,
    S_EMIT_P,
    S_EMIT_S,
    S_EMIT_N
  } state_e;

  state_e state_q, state_d;

  assign in_ready_o = (state_q == S_IDLE);

  always_comb begin
    ctl_o   = '0;
    ctl_o.sel = SEL_NONE;
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          ctl_o.accept = 1'b1;
          state_d      = S_DECODE;
        end
      end
      S_DECODE: begin
        ctl_o.decode = 1'b1;
        if (sts_i.is_put && sts_i.is_tab) state_d = S_DIV;
        else if (sts_i.is_put)            state_d = S_LINE;
        else                              state_d = S_EMIT_N;
      end
      S_DIV: begin
        ctl_o.div_step = 1'b1;
        if (sts_i.div_done) state_d = S_TAB;
      end
      S_TAB: begin
        ctl_o.tab_fix = 1'b1;
        state_d       = S_LINE;
      end
      S_LINE: begin
        ctl_o.line = 1'b1;
        state_d    = S_SCROLL;
      end
      S_SCROLL: begin
        ctl_o.scroll = 1'b1;
        if (sts_i.has_prim)        state_d = S_EMIT_P;
        else if (sts_i.has_scroll) state_d = S_EMIT_S;
        else                       state_d = S_EMIT_N;
      end
      S_EMIT_P: begin
        if (sts_i.out_free) begin
          ctl_o.emit = 1'b1;
          ctl_o.sel  = SEL_PRIM;
          ctl_o.last = !sts_i.has_scroll;
          state_d    = sts_i.has_scroll ? S_EMIT_S : S_IDLE;
        end
      end
      S_EMIT_S: begin
        if (sts_i.out_free) begin
          ctl_o.emit = 1'b1;
          ctl_o.sel  = SEL_SCROLL;
          ctl_o.last = 1'b1;
          state_d    = S_IDLE;
        end
      end
      S_EMIT_N: begin
        if (sts_i.out_free) begin
          ctl_o.emit = 1'b1;
          ctl_o.sel  = SEL_NONE;
          ctl_o.last = 1'b1;
          state_d    = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// ----- rtl/core/tce_dp.sv -----
module tce_dp import tce_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  cfg_t       cfg_i,
  input  logic [7:0] char_code_i,
  input  logic       parse_escapes_i,
  input  logic       last_of_write_i,
  input  ctrl_cmd_t  ctl_i,
  output ctrl_sts_t  sts_o,
  input  logic       res_ready_i,
  output logic       res_valid_o,
  output res_t       res_o
);

  localparam logic [DIV_CNT_W-1:0] DIV_LAST = DIV_CNT_W'(CUR_W - 1);

  // latched item
  logic [7:0] char_q;
  logic       pe_q, lw_q;

  // console state
  logic [CUR_W-1:0] cur_x_q, cur_x_d, cur_y_q, cur_y_d;
  logic [23:0]      fore_q, fore_d, back_q, back_d;
  logic             esc_q, esc_d, tgt_q, tgt_d;
  logic [23:0]      cacc_q, cacc_d;
  logic [7:0]       chan_q, chan_d;
  logic [1:0]       idx_q, idx_d;
  logic [31:0]      count_q, count_d;
  logic             ended_q, ended_d;

  // per-item working registers
  logic [XW_W-1:0]      xw_q, xw_d;
  logic [11:0]          y2_q, y2_d, t_q, t_d;
  logic                 scroll_q, scroll_d;
  logic                 has_prim_q, has_prim_d;
  res_t                 prim_q, prim_d;
  logic [CUR_W-1:0]     off_q, off_d;
  logic [CUR_W-1:0]     dq_q, dq_d, rem_q, rem_d;
  logic [DIV_CNT_W-1:0] dcnt_q, dcnt_d;

  // result register
  logic res_valid_q, res_valid_d;
  res_t res_q, res_d;

  logic                 is_put;
  logic [11:0]          cw12, chh12, lh12;
  logic [CUR_W-1:0]     cell_x;
  logic [11:0]          cell_xe, cell_ye, glyph_xw, y2_nl, t_nl, off_full;
  logic [11:0]          dig_mul;
  logic [TAB_P_W-1:0]   tab_p;
  logic [CUR_W:0]       rem_sh;
  logic                 rem_ge;
  logic [CMP_W-1:0]     rem_sub;
  logic                 nl;
  logic [23:0]          close_color;

  assign cw12  = {5'd0, cfg_i.cw};
  assign chh12 = {5'd0, cfg_i.chh};
  assign lh12  = {5'd0, cfg_i.lh};

  assign is_put = !ended_q && !esc_q && (char_q != CH_NUL) &&
                  !(pe_q && char_q == CH_ESC);

  // backspace steps back one cell, stopping at column zero
  assign cell_x   = (char_q == CH_BS) ?
                    (({1'b0, cur_x_q} >= cw12) ? cur_x_q - CUR_W'(cfg_i.cw) : '0) :
                    cur_x_q;
  assign cell_xe  = {1'b0, cell_x} + cw12 - 12'd1;
  assign cell_ye  = {1'b0, cur_y_q} + chh12 - 12'd1;
  assign glyph_xw = {1'b0, cur_x_q} + cw12;

  assign dig_mul = {1'b0, chan_q, 3'd0} + {3'd0, chan_q, 1'b0} +
                   {4'd0, char_q - CH_ZERO};
  assign close_color = cacc_q | {16'd0, chan_q};

  // tab remainder, one quotient bit per step
  assign tab_p   = TAB_P_W'(cfg_i.cw) * TAB_P_W'(TAB_STOP_CELLS);
  assign rem_sh  = {rem_q, dq_q[CUR_W-1]};
  assign rem_ge  = CMP_W'(rem_sh) >= CMP_W'(tab_p);
  assign rem_sub = CMP_W'(rem_sh) - CMP_W'(tab_p);

  assign nl    = (xw_q >= XW_W'(cfg_i.sw)) || (char_q == CH_LF);
  assign y2_nl = {1'b0, cur_y_q} + lh12;
  assign t_nl  = {1'b0, cur_y_q} + {lh12[10:0], 1'b0};
  assign off_full = t_q - cfg_i.th;

  always_comb begin
    cur_x_d    = cur_x_q;
    cur_y_d    = cur_y_q;
    fore_d     = fore_q;
    back_d     = back_q;
    esc_d      = esc_q;
    tgt_d      = tgt_q;
    cacc_d     = cacc_q;
    chan_d     = chan_q;
    idx_d      = idx_q;
    count_d    = count_q;
    ended_d    = ended_q;
    xw_d       = xw_q;
    y2_d       = y2_q;
    t_d        = t_q;
    scroll_d   = scroll_q;
    has_prim_d = has_prim_q;
    prim_d     = prim_q;
    off_d      = off_q;
    dq_d       = dq_q;
    rem_d      = rem_q;
    dcnt_d     = dcnt_q;
    res_d      = res_q;
    res_valid_d = res_valid_q & ~res_ready_i;

    if (ctl_i.decode) begin
      has_prim_d = 1'b0;
      scroll_d   = 1'b0;
      dq_d       = cur_x_q;
      rem_d      = '0;
      dcnt_d     = '0;
      xw_d       = XW_W'(cur_x_q);
      prim_d       = '0;
      prim_d.xs    = cell_x;
      prim_d.ys    = cur_y_q;
      prim_d.xe    = sat11(cell_xe);
      prim_d.ye    = sat11(cell_ye);
      if (ended_q) begin
        // rest of an ended write draws nothing
      end else if (esc_q) begin
        case (char_q) inside
          CH_SEMI, CH_NUL: begin
            if (tgt_q) back_d = close_color;
            else       fore_d = close_color;
            esc_d = 1'b0;
            if (char_q == CH_NUL) ended_d = 1'b1;
          end
          CH_LO_B, CH_UP_B: tgt_d = 1'b1;
          CH_LO_F, CH_UP_F: tgt_d = 1'b0;
          CH_LO_R, CH_UP_R: cacc_d = tgt_q ? DEF_BG : DEF_FG;
          CH_COMMA: begin
            // commas past the green channel are ignored
            if (idx_q == 2'd0) begin
              cacc_d = cacc_q | {chan_q, 16'd0};
              idx_d  = 2'd1;
              chan_d = '0;
            end else if (idx_q == 2'd1) begin
              cacc_d = cacc_q | {8'd0, chan_q, 8'd0};
              idx_d  = 2'd2;
              chan_d = '0;
            end
          end
          [CH_ZERO:CH_NINE]: chan_d = (dig_mul > 12'd255) ? 8'hFF : dig_mul[7:0];
          default: ;
        endcase
      end else if (char_q == CH_NUL) begin
        ended_d = 1'b1;
      end else if (pe_q && char_q == CH_ESC) begin
        esc_d  = 1'b1;
        tgt_d  = 1'b0;
        cacc_d = '0;
        chan_d = '0;
        idx_d  = '0;
      end else begin
        count_d = count_q + 32'd1;
        if (char_q == CH_BS) begin
          has_prim_d = 1'b1;
          prim_d.cmd = CMD_FILL;
          xw_d       = XW_W'(cell_x);
        end else if (char_q != CH_TAB && char_q != CH_LF) begin
          has_prim_d   = 1'b1;
          prim_d.cmd   = CMD_GLYPH;
          prim_d.glyph = char_q;
          prim_d.fg    = fore_q;
          prim_d.bg    = back_q;
          xw_d         = XW_W'(glyph_xw);
        end
      end
    end

    if (ctl_i.div_step) begin
      rem_d  = rem_ge ? rem_sub[CUR_W-1:0] : rem_sh[CUR_W-1:0];
      dq_d   = {dq_q[CUR_W-2:0], 1'b0};
      dcnt_d = dcnt_q + DIV_CNT_W'(1);
    end

    if (ctl_i.tab_fix) begin
      xw_d = XW_W'(cur_x_q) + XW_W'(tab_p) - XW_W'(rem_q);
    end

    if (ctl_i.line) begin
      y2_d = {1'b0, cur_y_q};
      t_d  = t_nl;
      if (nl) begin
        xw_d     = '0;
        y2_d     = y2_nl;
        scroll_d = (t_nl >= cfg_i.th);
      end
    end

    if (ctl_i.scroll) begin
      cur_x_d = (|xw_q[XW_W-1:CUR_W]) ? MAX11 : xw_q[CUR_W-1:0];
      if (scroll_q) begin
        off_d = sat11(off_full);
        // after the shift the cursor lands on text height minus line height
        cur_y_d = (cfg_i.th >= lh12) ? sat11(cfg_i.th - lh12) : '0;
      end else begin
        cur_y_d = sat11(y2_q);
      end
    end

    if (ctl_i.emit) begin
      res_valid_d = 1'b1;
      res_d       = '0;
      case (ctl_i.sel)
        SEL_PRIM:   res_d = prim_q;
        SEL_SCROLL: begin
          res_d.cmd = CMD_SCROLL;
          res_d.ys  = off_q;
          res_d.xe  = (cfg_i.sw == 12'd0) ? '0 : sat11(cfg_i.sw - 12'd1);
          res_d.ye  = sat11(cfg_i.th - 12'd1);
          res_d.bg  = DEF_BG;
        end
        default: res_d.cmd = CMD_NONE;
      endcase
      res_d.cur_x = cur_x_q;
      res_d.cur_y = cur_y_q;
      res_d.count = count_q;
      res_d.last  = ctl_i.last;
      // end of write: colors, parser and byte count back to defaults
      if (ctl_i.last && lw_q) begin
        fore_d  = DEF_FG;
        back_d  = DEF_BG;
        esc_d   = 1'b0;
        tgt_d   = 1'b0;
        cacc_d  = '0;
        chan_d  = '0;
        idx_d   = '0;
        count_d = '0;
        ended_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_x_q     <= '0;
      cur_y_q     <= '0;
      fore_q      <= DEF_FG;
      back_q      <= DEF_BG;
      esc_q       <= 1'b0;
      tgt_q       <= 1'b0;
      cacc_q      <= '0;
      chan_q      <= '0;
      idx_q       <= '0;
      count_q     <= '0;
      ended_q     <= 1'b0;
      res_valid_q <= 1'b0;
    end else begin
      cur_x_q     <= cur_x_d;
      cur_y_q     <= cur_y_d;
      fore_q      <= fore_d;
      back_q      <= back_d;
      esc_q       <= esc_d;
      tgt_q       <= tgt_d;
      cacc_q      <= cacc_d;
      chan_q      <= chan_d;
      idx_q       <= idx_d;
      count_q     <= count_d;
      ended_q     <= ended_d;
      res_valid_q <= res_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.accept) begin
      char_q <= char_code_i;
      pe_q   <= parse_escapes_i;
      lw_q   <= last_of_write_i;
    end
    xw_q       <= xw_d;
    y2_q       <= y2_d;
    t_q        <= t_d;
    scroll_q   <= scroll_d;
    has_prim_q <= has_prim_d;
    prim_q     <= prim_d;
    off_q      <= off_d;
    dq_q       <= dq_d;
    rem_q      <= rem_d;
    dcnt_q     <= dcnt_d;
    res_q      <= res_d;
  end

  assign sts_o.is_put     = is_put;
  assign sts_o.is_tab     = (char_q == CH_TAB);
  assign sts_o.div_done   = (dcnt_q == DIV_LAST);
  assign sts_o.has_prim   = has_prim_q;
  assign sts_o.has_scroll = scroll_q;
  assign sts_o.out_free   = !res_valid_q || res_ready_i;

  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

endmodule

// ----- rtl/core/text_console_char_engine.sv -----
// text console character engine: takes one text byte per input transfer and
// keeps a pixel cursor, foreground and background colors and a color escape
// parser; each byte yields one or two drawing commands (glyph, background
// fill, scroll-up-and-clear, or none) on the output stream, the final one
// flagged by tlast, each carrying the cursor after the byte and the count of
// bytes handled as text (not escape or zero bytes) in the current write. a
// sequencer walks each byte through decode, the bit-serial remainder unit
// that finds the next tab stop for a tab (one bit of the 11-bit column per
// cycle), line and scroll handling for a text byte, and the emit of each
// command. one item is in flight at a time; the output register lets the
// next byte be taken while the last command still waits. configuration
// registers sit on the apb port at byte addresses 4*i; the user must see
// that they are written only while the engine is idle, which the block does
// not enforce. the derived text height settles in the cycle after a write
module text_console_char_engine import tce_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // configuration port
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready,
  // text byte stream
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [7:0]            s_axis_tdata,   // char_code
  input  logic                  s_axis_tuser,   // parse_escapes
  input  logic                  s_axis_tlast,   // last_of_write
  // drawing command stream
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  // x_start, y_start, x_end, y_end, glyph, fg_color, bg_color, cursor_x,
  // cursor_row, written_count, zero pad
  output logic [159:0]          m_axis_tdata,
  output logic [1:0]            m_axis_tuser,   // cmd
  output logic                  m_axis_tlast    // last
);

  cfg_t      cfg;
  ctrl_cmd_t ctl;
  ctrl_sts_t sts;
  res_t      res;

  // register file with the derived text height
  tce_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // sequencer: decode, tab remainder, line step, scroll, emit
  tce_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .sts_i      (sts),
    .ctl_o      (ctl)
  );

  // cursor, colors, escape parser and result register
  tce_dp u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_i           (cfg),
    .char_code_i     (s_axis_tdata),
    .parse_escapes_i (s_axis_tuser),
    .last_of_write_i (s_axis_tlast),
    .ctl_i           (ctl),
    .sts_o           (sts),
    .res_ready_i     (m_axis_tready),
    .res_valid_o     (m_axis_tvalid),
    .res_o           (res)
  );

  // pack the result, first field in the lowest bits
  assign m_axis_tdata = {6'd0, res.count, res.cur_y, res.cur_x, res.bg, res.fg,
                         res.glyph, res.ye, res.xe, res.ys, res.xs};
  assign m_axis_tuser = res.cmd;
  assign m_axis_tlast = res.last;

endmodule

// ----- dv/tb_top.sv -----
`timescale 1ns / 1ps

module tb_top;
  import tce_pkg::*;

  // clock period is 10 ns, the run is cut off at RUN_LIMIT_NS
  localparam int          RUN_LIMIT_NS = 10_000_000;
  localparam int          PHASES       = 8;
  localparam int          PHASE_BYTES  = 125;
  // at most two commands per byte
  localparam int          SETTLE_CYCLES = 40;
  localparam int          HOLD_CYCLES   = 300;

  // configuration registers in address order, byte address is 4 * index
  typedef enum int {
    REG_CHAR_W    = 0,
    REG_CHAR_H    = 1,
    REG_LINE_H    = 2,
    REG_SCREEN_W  = 3,
    REG_SCREEN_H  = 4,
    REG_RESV_TOP  = 5
  } reg_idx_e;

  // one text byte as it travels on the input stream
  typedef struct {
    logic [7:0] code;
    bit         esc_on;
    bit         ends_write;
  } text_byte_t;

  // keeps its own copy of the console state, works out the drawing commands
  // for every accepted byte and checks the commands coming out in order
  class draw_scoreboard;
    int unsigned char_w, char_h, line_h, screen_w, screen_h, resv_top;
    int unsigned col_px, row_px, x_px, y_px;
    int unsigned fore, back, color_acc, chan_acc, chan_idx, nbytes;
    bit          in_escape, to_back, write_done;
    res_t        this_byte[$];
    res_t        expected_cmds[$];
    int unsigned mismatches;

    function new();
      char_w = 8; char_h = 16; line_h = 16;
      screen_w = 1024; screen_h = 768; resv_top = 0;
      col_px = 0; row_px = 0;
      mismatches = 0;
      end_write();
    endfunction

    function void set_reg(reg_idx_e idx, int unsigned val);
      case (idx)
        REG_CHAR_W:   char_w   = val & 32'h7F;
        REG_CHAR_H:   char_h   = val & 32'h7F;
        REG_LINE_H:   line_h   = val & 32'h7F;
        REG_SCREEN_W: screen_w = val & 32'hFFF;
        REG_SCREEN_H: screen_h = val & 32'hFFF;
        REG_RESV_TOP: resv_top = val & 32'hFF;
        default: ;
      endcase
    endfunction

    // colors and parser go back to defaults, byte count restarts
    function void end_write();
      fore = DEF_FG; back = DEF_BG;
      in_escape = 0; to_back = 0;
      color_acc = 0; chan_acc = 0; chan_idx = 0;
      nbytes = 0; write_done = 0;
    endfunction

    function logic [CUR_W-1:0] clip(int unsigned v);
      return (v > 2047) ? MAX11 : v[CUR_W-1:0];
    endfunction

    function int unsigned at_least_one(int unsigned v);
      return (v == 0) ? 1 : v;
    endfunction

    function void add(cmd_e k, int unsigned xs, int unsigned ys, int unsigned xe,
                      int unsigned ye, int unsigned g, int unsigned fg, int unsigned bg);
      res_t r;
      r       = '0;
      r.cmd   = k;
      r.xs    = clip(xs);
      r.ys    = clip(ys);
      r.xe    = clip(xe);
      r.ye    = clip(ye);
      r.glyph = g[7:0];
      r.fg    = fg[23:0];
      r.bg    = bg[23:0];
      this_byte.push_back(r);
    endfunction

    function void advance_line();
      int unsigned lh, h, off, xe;
      lh = at_least_one(line_h);
      h  = (screen_h > resv_top) ? screen_h - resv_top : 1;
      x_px = 0;
      y_px += lh;
      if (y_px + lh >= h) begin
        off = y_px + lh - h;
        xe  = (screen_w > 0) ? screen_w - 1 : 0;
        add(CMD_SCROLL, 0, off, xe, h - 1, 0, 0, DEF_BG);
        y_px = (y_px >= off) ? y_px - off : 0;
      end
    endfunction

    function void draw_char(logic [7:0] c);
      int unsigned cw, chh, p;
      cw  = at_least_one(char_w);
      chh = at_least_one(char_h);
      x_px = col_px;
      y_px = row_px;
      if (c == CH_BS) begin
        if (x_px > 0) x_px = (x_px >= cw) ? x_px - cw : 0;
        add(CMD_FILL, x_px, y_px, x_px + cw - 1, y_px + chh - 1, 0, 0, DEF_BG);
      end else if (c == CH_TAB) begin
        p = TAB_STOP_CELLS * cw;
        x_px += p - (x_px % p);
      end else if (c != CH_LF) begin
        add(CMD_GLYPH, x_px, y_px, x_px + cw - 1, y_px + chh - 1, c, fore, back);
        x_px += cw;
      end
      if (x_px >= screen_w || c == CH_LF) advance_line();
      col_px = clip(x_px);
      row_px = clip(y_px);
    endfunction

    function void eat_escape_byte(logic [7:0] c);
      int unsigned v;
      if (c == CH_SEMI || c == CH_NUL) begin
        if (to_back) back = (color_acc | chan_acc) & 32'hFFFFFF;
        else         fore = (color_acc | chan_acc) & 32'hFFFFFF;
        in_escape = 0;
        if (c == CH_NUL) write_done = 1;
      end else if (c == CH_LO_B || c == CH_UP_B) begin
        to_back = 1;
      end else if (c == CH_LO_F || c == CH_UP_F) begin
        to_back = 0;
      end else if (c == CH_LO_R || c == CH_UP_R) begin
        color_acc = to_back ? DEF_BG : DEF_FG;
      end else if (c == CH_COMMA) begin
        if (chan_idx == 0) begin
          color_acc |= chan_acc << 16;
          chan_idx = 1;
          chan_acc = 0;
        end else if (chan_idx == 1) begin
          color_acc |= chan_acc << 8;
          chan_idx = 2;
          chan_acc = 0;
        end
        color_acc &= 32'hFFFFFF;
      end else if (c >= CH_ZERO && c <= CH_NINE) begin
        v = chan_acc * 10 + (c - CH_ZERO);
        chan_acc = (v > 255) ? 255 : v;
      end
    endfunction

    function void note_byte(text_byte_t b);
      this_byte.delete();
      if (write_done) begin
        // rest of an ended write draws nothing
      end else if (in_escape) begin
        eat_escape_byte(b.code);
      end else if (b.code == CH_NUL) begin
        write_done = 1;
      end else if (b.esc_on && b.code == CH_ESC) begin
        in_escape = 1; to_back = 0;
        color_acc = 0; chan_acc = 0; chan_idx = 0;
      end else begin
        nbytes++;
        draw_char(b.code);
      end
      if (this_byte.size() == 0) add(CMD_NONE, 0, 0, 0, 0, 0, 0, 0);
      foreach (this_byte[k]) begin
        this_byte[k].cur_x = col_px[CUR_W-1:0];
        this_byte[k].cur_y = row_px[CUR_W-1:0];
        this_byte[k].count = nbytes;
        this_byte[k].last  = (k == this_byte.size() - 1);
        expected_cmds.push_back(this_byte[k]);
      end
      if (b.ends_write) end_write();
    endfunction

    function void cmp(string name, logic [31:0] exp_v, logic [31:0] got_v);
      if (exp_v !== got_v) begin
        $error("%s: expected %0h, actual %0h", name, exp_v, got_v);
        mismatches++;
      end
    endfunction

    function void check_cmd(res_t got);
      res_t exp_r;
      if (expected_cmds.size() == 0) begin
        $error("cmd: expected nothing, actual %0h", got.cmd);
        mismatches++;
        return;
      end
      exp_r = expected_cmds.pop_front();
      cmp("cmd",           exp_r.cmd,   got.cmd);
      cmp("x_start",       exp_r.xs,    got.xs);
      cmp("y_start",       exp_r.ys,    got.ys);
      cmp("x_end",         exp_r.xe,    got.xe);
      cmp("y_end",         exp_r.ye,    got.ye);
      cmp("glyph",         exp_r.glyph, got.glyph);
      cmp("fg_color",      exp_r.fg,    got.fg);
      cmp("bg_color",      exp_r.bg,    got.bg);
      cmp("cursor_x",      exp_r.cur_x, got.cur_x);
      cmp("cursor_row",    exp_r.cur_y, got.cur_y);
      cmp("written_count", exp_r.count, got.count);
      cmp("last",          exp_r.last,  got.last);
    endfunction
  endclass

  // every input of the engine starts at a known value
  logic                  clk_i         = 1'b0;
  logic                  rst_ni        = 1'b0;
  logic                  psel          = 1'b0;
  logic                  penable       = 1'b0;
  logic                  pwrite        = 1'b0;
  logic [APB_ADDR_W-1:0] paddr         = '0;
  logic [APB_DATA_W-1:0] pwdata        = '0;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [7:0]            s_axis_tdata  = '0;   // char_code
  logic                  s_axis_tuser  = 1'b0; // parse_escapes
  logic                  s_axis_tlast  = 1'b0; // last_of_write
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  // x_start, y_start, x_end, y_end, glyph, fg_color, bg_color, cursor_x,
  // cursor_row, written_count, zero pad
  logic [159:0]          m_axis_tdata;
  logic [1:0]            m_axis_tuser;         // cmd
  logic                  m_axis_tlast;         // last

  draw_scoreboard sb = new();
  text_byte_t     text_q[$];

  // calm: neither side idles; hold_req: the receiver holds off once
  bit calm     = 1'b0;
  bit hold_req = 1'b0;

  always #5 clk_i = ~clk_i;

  text_console_char_engine dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  // idle length: mostly none or short, now and then a long one
  function automatic int pick_idle();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 40);
  endfunction

  function automatic void push_byte(logic [7:0] code, bit esc_on, bit ends_write);
    text_byte_t b;
    b.code       = code;
    b.esc_on     = esc_on;
    b.ends_write = ends_write;
    text_q.push_back(b);
  endfunction

  // color escape: well formed ones maybe pick a target, maybe load the default and
  // give up to four channels; broken ones carry random bytes
  function automatic void queue_escape(bit well_formed);
    int n, r;
    push_byte(CH_ESC, 1'b1, 1'b0);
    if (!well_formed) begin
      n = $urandom_range(1, 5);
      repeat (n) push_byte(8'($urandom_range(0, 255)), 1'($urandom), 1'b0);
      return;
    end
    case ($urandom_range(0, 4))
      0:       push_byte(CH_LO_F, 1'($urandom), 1'b0);
      1:       push_byte(CH_UP_F, 1'($urandom), 1'b0);
      2:       push_byte(CH_LO_B, 1'($urandom), 1'b0);
      3:       push_byte(CH_UP_B, 1'($urandom), 1'b0);
      default: ;
    endcase
    if ($urandom_range(0, 3) == 0)
      push_byte($urandom_range(0, 1) ? CH_LO_R : CH_UP_R, 1'($urandom), 1'b0);
    n = $urandom_range(0, 4);
    for (int i = 0; i < n; i++) begin
      if (i > 0) push_byte(CH_COMMA, 1'($urandom), 1'b0);
      repeat ($urandom_range(1, 3))
        push_byte(8'(CH_ZERO + $urandom_range(0, 9)), 1'($urandom), 1'b0);
    end
    r = $urandom_range(0, 19);
    if (r < 18)       push_byte(CH_SEMI, 1'($urandom), 1'b0);
    else if (r == 18) push_byte(CH_NUL, 1'($urandom), 1'b0);
    // otherwise left open, the next bytes land in the escape
  endfunction

  // one write: a run of text pieces, the final byte ends the write
  function automatic void queue_write();
    int pieces, kind;
    pieces = $urandom_range(1, 16);
    for (int i = 0; i < pieces; i++) begin
      kind = $urandom_range(0, 99);
      if (kind < 40)      push_byte(8'($urandom_range(8'h20, 8'h7E)), 1'($urandom), 1'b0);
      else if (kind < 50) push_byte(CH_LF, 1'($urandom), 1'b0);
      else if (kind < 55) push_byte(CH_TAB, 1'($urandom), 1'b0);
      else if (kind < 60) push_byte(CH_BS, 1'($urandom), 1'b0);
      else if (kind < 78) queue_escape(1'b1);
      else if (kind < 84) queue_escape(1'b0);
      else if (kind < 98) push_byte(8'($urandom_range(0, 255)), 1'($urandom), 1'b0);
      else                push_byte(CH_NUL, 1'($urandom), 1'b0);
    end
    text_q[$].ends_write = 1'b1;
  endfunction

  // apb write: setup cycle, access cycle until pready, then an idle cycle
  task automatic write_reg(reg_idx_e idx, int unsigned val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= APB_ADDR_W'(idx * 4);
    pwdata  <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    sb.set_reg(idx, val);
    @(posedge clk_i);
  endtask

  task automatic setup_screen(int unsigned cw, int unsigned chh, int unsigned lh,
                              int unsigned sw, int unsigned sh, int unsigned rt);
    write_reg(REG_CHAR_W, cw);
    write_reg(REG_CHAR_H, chh);
    write_reg(REG_LINE_H, lh);
    write_reg(REG_SCREEN_W, sw);
    write_reg(REG_SCREEN_H, sh);
    write_reg(REG_RESV_TOP, rt);
  endtask

  // offers every queued byte; valid stays up across back-to-back transfers
  task automatic send_bytes();
    text_byte_t b;
    int         gap;
    while (text_q.size() > 0) begin
      b   = text_q.pop_front();
      gap = calm ? 0 : pick_idle();
      if (gap > 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      s_axis_tvalid <= 1'b1;
      s_axis_tdata  <= b.code;
      s_axis_tuser  <= b.esc_on;
      s_axis_tlast  <= b.ends_write;
      do @(posedge clk_i); while (!s_axis_tready);
      sb.note_byte(b);
    end
    s_axis_tvalid <= 1'b0;
  endtask

  task automatic wait_drained();
    while (sb.expected_cmds.size() != 0) @(posedge clk_i);
  endtask

  // command receiver: checks each transfer, stalls at random, and holds off
  // for a long stretch when asked so that the engine backs up into its input
  initial begin
    int   stall_left, hold_left, k;
    res_t got;
    stall_left = 0;
    hold_left  = 0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && m_axis_tvalid && m_axis_tready) begin
        got       = '0;
        got.cmd   = cmd_e'(m_axis_tuser);
        got.xs    = m_axis_tdata[10:0];
        got.ys    = m_axis_tdata[21:11];
        got.xe    = m_axis_tdata[32:22];
        got.ye    = m_axis_tdata[43:33];
        got.glyph = m_axis_tdata[51:44];
        got.fg    = m_axis_tdata[75:52];
        got.bg    = m_axis_tdata[99:76];
        got.cur_x = m_axis_tdata[110:100];
        got.cur_y = m_axis_tdata[121:111];
        got.count = m_axis_tdata[153:122];
        got.last  = m_axis_tlast;
        sb.check_cmd(got);
      end
      if (hold_req && hold_left == 0) begin
        hold_left = HOLD_CYCLES;
        hold_req  = 1'b0;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        m_axis_tready <= 1'b0;
      end else begin
        k = calm ? 0 : pick_idle();
        stall_left = (k > 0) ? k - 1 : 0;
        m_axis_tready <= (k == 0);
      end
    end
  end

  // stimulus
  initial begin
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: reset setup, column-zero backspace, top byte, tab, newline,
    // escape byte drawn when parsing is off, saturating channel with extra
    // commas, default reload, zero byte closing an escape and ending the
    // write, write end inside an escape, bare zero byte
    push_byte(CH_BS, 1'b1, 1'b0);
    push_byte("A", 1'b1, 1'b0);
    push_byte(8'hFF, 1'b0, 1'b0);
    push_byte(CH_BS, 1'b1, 1'b0);
    push_byte(CH_TAB, 1'b1, 1'b0);
    push_byte(CH_LF, 1'b1, 1'b0);
    push_byte(CH_ESC, 1'b0, 1'b0);
    push_byte(CH_ESC, 1'b1, 1'b0);
    push_byte(CH_UP_B, 1'b0, 1'b0);
    repeat (3) push_byte("9", 1'b1, 1'b0);
    repeat (3) push_byte(CH_COMMA, 1'b0, 1'b0);
    push_byte("5", 1'b0, 1'b0);
    push_byte(CH_SEMI, 1'b1, 1'b0);
    push_byte("x", 1'b1, 1'b0);
    push_byte(CH_ESC, 1'b1, 1'b0);
    push_byte(CH_UP_R, 1'b1, 1'b0);
    push_byte(CH_NUL, 1'b1, 1'b0);
    push_byte("Z", 1'b1, 1'b1);
    push_byte(CH_ESC, 1'b1, 1'b0);
    push_byte("7", 1'b1, 1'b1);
    push_byte(CH_NUL, 1'b0, 1'b1);
    send_bytes();

    for (int ph = 0; ph < PHASES; ph++) begin
      // registers change only with the engine idle
      wait_drained();
      repeat (SETTLE_CYCLES) @(posedge clk_i);
      case (ph)
        0: setup_screen(0, 0, 0, 64, 64, 0);            // zero cells, smallest screen
        1: setup_screen(64, 64, 64, 2048, 2048, 255);   // largest everything
        2: setup_screen(1, 1, 1, 64, 64, 255);          // text area squeezed to one row
        PHASES - 1: setup_screen(8, 16, 16, 1024, 768, 0);
        default:
          setup_screen($urandom_range(1, 64), $urandom_range(1, 64), $urandom_range(1, 64),
                       $urandom_range(64, 2048), $urandom_range(64, 2048),
                       $urandom_range(0, 1) ? 0 : $urandom_range(1, 255));
      endcase
      calm = (ph % 3 == 2);
      if (ph == 2) hold_req = 1'b1;
      while (text_q.size() < PHASE_BYTES) queue_write();
      send_bytes();
    end

    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (sb.mismatches == 0 && sb.expected_cmds.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  // hard stop far beyond the slowest correct run
  initial begin
    #(RUN_LIMIT_NS);
    $display("Mismatches found");
    $finish;
  end

endmodule

// ----- text_console_char_engine.f -----
rtl/core/tce_pkg.sv
rtl/core/tce_cfg.sv
rtl/core/tce_ctrl.sv
rtl/core/tce_dp.sv
rtl/core/text_console_char_engine.sv
dv/tb_top.sv
